/* sv/xtkq_pkg.sv */
// ----------------------------------------------------------------------------
// xtkq_pkg
// shared types and constants of the xor trie rank query block
// ----------------------------------------------------------------------------
`default_nettype none
package xtkq_pkg;

    localparam int KEY_BITS_DEF = 32;
    localparam int MAX_KEYS_DEF = 1024;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_QUERY  = 2'd1,
        ACT_CLEAR  = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_BAD_RANK = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] key;
        logic [10:0] rank;
    } t_in;

    typedef struct packed {
        logic [31:0] xor_value;
        logic [1:0]  status;
        logic [10:0] stored_keys;
    } t_out;

    // control that travels down the row of level cells
    typedef struct packed {
        logic valid;
        logic is_ins;
        logic is_new;
    } t_ctl;

endpackage
`default_nettype wire

/* sv/xor_trie_kth_max_query.sv */
// ----------------------------------------------------------------------------
// xor_trie_kth_max_query
// binary trie of keys with per-node counts, k-th largest xor query
// ----------------------------------------------------------------------------
// Give a beat with start while busy is low. Insert and query walk a row of
// KEY_BITS level cells, each holding its own node memory; at every level the
// node read is registered as the beat comes in, and the update and hand-off
// to the next level follow in the next cycle. busy stays high from the accept
// until the edge that registers the result of the walk. Clear, a full insert,
// a bad rank and the unused action return on the next edge. The result shows
// on o_out for one cycle with o_valid; it cannot be held off.
`default_nettype none
module xor_trie_kth_max_query #(
    parameter int KEY_BITS = xtkq_pkg::KEY_BITS_DEF,
    parameter int MAX_KEYS = xtkq_pkg::MAX_KEYS_DEF
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             start,
    output logic            busy,
    input  xtkq_pkg::t_in   i_in,
    output logic            o_valid,
    output xtkq_pkg::t_out  o_out
);

    localparam int IW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int CW = $clog2(MAX_KEYS + 1);
    localparam int RW = (CW > 11) ? CW : 11;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            r_root_new, n_root_new;
    logic            r_valid, n_valid;
    xtkq_pkg::t_out  r_out, n_out;

    xtkq_pkg::t_ctl  ctl_c  [0:KEY_BITS];
    logic [IW-1:0]   idx_c  [0:KEY_BITS];
    logic [KEY_BITS-1:0] key_c [0:KEY_BITS];
    logic [CW-1:0]   rank_c [0:KEY_BITS];
    logic [KEY_BITS-1:0] res_c [0:KEY_BITS];

    logic            acc, clr, full, bad;
    logic [KEY_BITS-1:0] key_w;
    logic [31:0]     res_w;
    logic [RW-1:0]   rank_x;

    always_comb begin
        key_w = '0;
        for (int i = 0; i < KEY_BITS; i++) begin
            if (i < 32) key_w[i] = i_in.key[i];
        end
        res_w = '0;
        for (int i = 0; i < 32; i++) begin
            if (i < KEY_BITS) res_w[i] = res_c[KEY_BITS][i];
        end
    end

    assign busy   = (r_state == S_RUN);
    assign acc    = start && !busy;
    assign rank_x = RW'(i_in.rank);
    assign full   = (r_cnt == CW'(MAX_KEYS));
    assign bad    = (rank_x == '0) || (rank_x > RW'(r_cnt));
    assign clr    = acc && (i_in.action == xtkq_pkg::ACT_CLEAR);

    always_comb begin
        ctl_c[0].valid  = 1'b0;
        ctl_c[0].is_ins = (i_in.action == xtkq_pkg::ACT_INSERT);
        ctl_c[0].is_new = r_root_new;
        idx_c[0]  = '0;
        key_c[0]  = key_w;
        rank_c[0] = CW'(rank_x);
        res_c[0]  = '0;

        n_state    = r_state;
        n_cnt      = r_cnt;
        n_root_new = r_root_new;
        n_valid    = 1'b0;
        n_out      = r_out;

        if (acc) begin
            n_out.xor_value   = '0;
            n_out.status      = xtkq_pkg::ST_OK;
            case (i_in.action)
                xtkq_pkg::ACT_INSERT: begin
                    if (full) begin
                        n_out.status = xtkq_pkg::ST_FULL;
                        n_valid      = 1'b1;
                    end else begin
                        ctl_c[0].valid = 1'b1;
                        n_cnt          = r_cnt + CW'(1);
                        n_root_new     = 1'b0;
                        n_state        = S_RUN;
                    end
                end
                xtkq_pkg::ACT_QUERY: begin
                    if (bad) begin
                        n_out.status = xtkq_pkg::ST_BAD_RANK;
                        n_valid      = 1'b1;
                    end else begin
                        ctl_c[0].valid = 1'b1;
                        n_state        = S_RUN;
                    end
                end
                xtkq_pkg::ACT_CLEAR: begin
                    n_cnt      = '0;
                    n_root_new = 1'b1;
                    n_valid    = 1'b1;
                end
                default: begin
                    n_valid = 1'b1;
                end
            endcase
            n_out.stored_keys = 11'(n_cnt);
        end else if (ctl_c[KEY_BITS].valid) begin
            n_valid = 1'b1;
            n_state = S_IDLE;
            if (!ctl_c[KEY_BITS].is_ins) n_out.xor_value = res_w;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt      <= '0;
            r_root_new <= 1'b1;
            r_valid    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_root_new <= n_root_new;
            r_valid    <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_valid = r_valid;
    assign o_out   = r_out;

    for (genvar d = 0; d < KEY_BITS; d++) begin : g_lvl
        xtkq_cell #(
            .KB(KEY_BITS), .NODES(MAX_KEYS), .IW(IW), .CW(CW), .LEVEL(d)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_clear(clr),
            .i_ctl  (ctl_c[d]),
            .i_idx  (idx_c[d]),
            .i_key  (key_c[d]),
            .i_rank (rank_c[d]),
            .i_res  (res_c[d]),
            .o_ctl  (ctl_c[d+1]),
            .o_idx  (idx_c[d+1]),
            .o_key  (key_c[d+1]),
            .o_rank (rank_c[d+1]),
            .o_res  (res_c[d+1])
        );
    end

    a_quiet_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !o_valid) else $error("result beat while walking");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_KEYS)) else $error("key count above capacity");
    a_clear_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clr |=> o_valid && (o_out.stored_keys == '0)) else $error("clear not answered");
    a_walk_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl_c[KEY_BITS].valid |-> busy) else $error("walk ended while idle");

endmodule
`default_nettype wire

/* sv/xtkq_cell.sv */
// ----------------------------------------------------------------------------
// xtkq_cell
// one trie level: node memory, level allocator, one step of insert or query
// ----------------------------------------------------------------------------
`default_nettype none
module xtkq_cell #(
    parameter int KB    = xtkq_pkg::KEY_BITS_DEF,
    parameter int NODES = xtkq_pkg::MAX_KEYS_DEF,
    parameter int IW    = 10,
    parameter int CW    = 11,
    parameter int LEVEL = 0
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_clear,
    input  xtkq_pkg::t_ctl    i_ctl,
    input  wire  [IW-1:0]     i_idx,
    input  wire  [KB-1:0]     i_key,
    input  wire  [CW-1:0]     i_rank,
    input  wire  [KB-1:0]     i_res,
    output xtkq_pkg::t_ctl    o_ctl,
    output logic [IW-1:0]     o_idx,
    output logic [KB-1:0]     o_key,
    output logic [CW-1:0]     o_rank,
    output logic [KB-1:0]     o_res
);

    localparam int BI = KB - 1 - LEVEL;
    localparam int EW = 2 * IW + 2 * CW;

    // entry: zero ptr, one ptr, zero count, one count
    logic [EW-1:0] mem [0:NODES-1];

    logic              r_ph;
    xtkq_pkg::t_ctl    r_ctl;
    logic [IW-1:0]     r_idx;
    logic [KB-1:0]     r_key;
    logic [CW-1:0]     r_rank;
    logic [KB-1:0]     r_res;
    logic [EW-1:0]     r_rd;
    logic [IW:0]       r_alloc;
    logic [IW:0]       n_alloc;

    logic [EW-1:0] ent;
    logic [IW-1:0] zp, op;
    logic [CW-1:0] zc, oc, cnt_b, opc;
    logic          b, need_new, wr;
    logic [IW-1:0] cptr;
    logic [EW-1:0] wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph    <= 1'b0;
            r_alloc <= '0;
        end else begin
            r_ph    <= i_ctl.valid;
            r_alloc <= n_alloc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.valid) begin
            r_ctl  <= i_ctl;
            r_idx  <= i_idx;
            r_key  <= i_key;
            r_rank <= i_rank;
            r_res  <= i_res;
            r_rd   <= mem[i_idx];
        end
        if (wr) begin
            mem[r_idx] <= wdata;
        end
    end

    always_comb begin
        // a freshly allocated node reads as empty
        ent      = r_ctl.is_new ? '0 : r_rd;
        zp       = ent[EW-1 -: IW];
        op       = ent[EW-1-IW -: IW];
        zc       = ent[2*CW-1 -: CW];
        oc       = ent[CW-1:0];
        b        = r_key[BI];
        cnt_b    = b ? oc : zc;
        need_new = (cnt_b == '0);
        cptr     = need_new ? r_alloc[IW-1:0] : (b ? op : zp);
        wr       = r_ph && r_ctl.is_ins;
        wdata    = b ? {zp, cptr, zc, oc + CW'(1)} : {cptr, op, zc + CW'(1), oc};
        opc      = b ? zc : oc;

        n_alloc  = r_alloc;
        if (i_clear) begin
            n_alloc = '0;
        end else if (wr && need_new) begin
            n_alloc = r_alloc + (IW+1)'(1);
        end

        o_ctl.valid  = r_ph;
        o_ctl.is_ins = r_ctl.is_ins;
        o_ctl.is_new = r_ctl.is_ins && need_new;
        o_key        = r_key;
        o_res        = r_res;
        o_rank       = r_rank;
        if (r_ctl.is_ins) begin
            o_idx = cptr;
        end else if (r_rank <= opc) begin
            o_res[BI] = 1'b1;
            o_idx     = b ? zp : op;
        end else begin
            o_rank = r_rank - opc;
            o_idx  = b ? op : zp;
        end
    end

endmodule
`default_nettype wire
